// ===== sv/clm_pkg.sv =====
// Shared types and constants for the circular list move engine.
`default_nettype none

package clm_pkg;

   localparam int NODE_W        = 11;
   localparam int MAX_NODES_DEF = 1024;

   localparam logic REQ_MOVE  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [NODE_W-1:0] node_moved;
      logic [NODE_W-1:0] node_target;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] forward_neighbour;
      logic [NODE_W-1:0] backward_neighbour;
      logic              bad_request;
   } rsp_type;

   // link table write selection
   typedef enum logic [2:0] {
      WR_NONE   = 3'd0,
      WR_INIT   = 3'd1,
      WR_UNLINK = 3'd2,
      WR_SPLICE = 3'd3,
      WR_CLOSE  = 3'd4
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       cap_x;
      logic       cap_y;
      logic       rd_y;
      logic       load_rsp;
      logic       sweep_step;
      logic       sweep_clr;
      wr_sel_type wr_sel;
   } cmd_type;

   typedef struct packed {
      logic req_x_ok;
      logic go_move;
      logic sweep_last;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/clm_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none

module clm_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/clm_ctrl.sv =====
// Sequencing state machine for ring rebuild, query and move.
`default_nettype none

module clm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic              csr_we,
   input  wire clm_pkg::sts_type  sts,
   output clm_pkg::cmd_type       cmd
);

   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_RD_X   = 8'b0000_0100,
      S_RD_Y   = 8'b0000_1000,
      S_CAP_Y  = 8'b0001_0000,
      S_SPLICE = 8'b0010_0000,
      S_CLOSE  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_sel = clm_pkg::WR_NONE;
      unique case (state_ff)
         S_INIT: begin
            cmd.wr_sel     = clm_pkg::WR_INIT;
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = sts.req_x_ok ? S_RD_X : S_DONE;
            end
         end
         S_RD_X: begin
            state_in = S_RD_Y;
         end
         S_RD_Y: begin
            cmd.cap_x = 1'b1;
            cmd.rd_y  = 1'b1;
            state_in  = sts.go_move ? S_CAP_Y : S_DONE;
         end
         S_CAP_Y: begin
            cmd.cap_y  = 1'b1;
            cmd.wr_sel = clm_pkg::WR_UNLINK;
            state_in   = S_SPLICE;
         end
         S_SPLICE: begin
            cmd.wr_sel = clm_pkg::WR_SPLICE;
            state_in   = S_CLOSE;
         end
         S_CLOSE: begin
            cmd.wr_sel = clm_pkg::WR_CLOSE;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      // a count write restarts the rebuild from the first node
      if (csr_we) begin
         cmd.sweep_clr = 1'b1;
         state_in      = S_INIT;
      end
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> state_ff == S_INIT)
      else $error("count write did not restart the rebuild");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
`endif

endmodule

`default_nettype wire

// ===== sv/clm_dp.sv =====
// Link tables, request registers and result register for the list engine.
`default_nettype none

module clm_dp #(
   parameter int MAX_NODES = clm_pkg::MAX_NODES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire clm_pkg::req_type              req_data,
   output clm_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [clm_pkg::NODE_W-1:0]    csr_wdata,
   input  wire clm_pkg::cmd_type              cmd,
   output clm_pkg::sts_type                   sts
);

   localparam int NODE_W = clm_pkg::NODE_W;
   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (NODE_W > CNT_W) ? NODE_W : CNT_W;
   localparam int LNK_W  = IDX_W + 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic [IDX_W-1:0] x_ff, y_ff, xf_ff, xb_ff, yf_ff, yf_in;
   logic             x_ok_ff, bad_ff, go_move_ff;
   clm_pkg::rsp_type rsp_ff, rsp_in;

   logic             req_x_ok, req_y_ok, req_bad, req_move;
   logic [CMP_W-1:0] cfg_val;
   logic [IDX_W-1:0] last_idx;

   logic             wr_en;
   logic [IDX_W-1:0] f_wr_addr, f_wr_data, b_wr_addr, b_wr_data;
   logic [IDX_W-1:0] f_rd_addr, f_rd_data, b_rd_data;

   // request checks against the current count
   assign req_move = (req_data.req_type == clm_pkg::REQ_MOVE);
   assign req_x_ok = (req_data.node_moved != '0)
                  && (CMP_W'(req_data.node_moved) <= CMP_W'(count_ff));
   assign req_y_ok = (req_data.node_target != '0)
                  && (CMP_W'(req_data.node_target) <= CMP_W'(count_ff));
   assign req_bad  = !req_x_ok
                  || (req_move && (!req_y_ok
                                   || (req_data.node_moved == req_data.node_target)));

   // count clamp
   assign cfg_val = CMP_W'(csr_wdata);
   always_comb begin
      priority if (cfg_val < CMP_W'(2)) begin
         count_in = CNT_W'(2);
      end else if (cfg_val > CMP_W'(MAX_NODES)) begin
         count_in = CNT_W'(MAX_NODES);
      end else begin
         count_in = CNT_W'(cfg_val);
      end
   end

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      priority if (cmd.sweep_clr) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = (sweep_ff == last_idx) ? '0 : IDX_W'(sweep_ff + IDX_W'(1));
      end else begin
         sweep_in = sweep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(MAX_NODES);
         sweep_ff <= '0;
      end else begin
         if (csr_we) begin
            count_ff <= count_in;
         end
         sweep_ff <= sweep_in;
      end
   end

   // y's successor after x is unlinked: if y was x's predecessor it now points past x
   assign yf_in = (y_ff == xb_ff) ? xf_ff : f_rd_data;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff       <= IDX_W'(req_data.node_moved - NODE_W'(1));
         y_ff       <= IDX_W'(req_data.node_target - NODE_W'(1));
         x_ok_ff    <= req_x_ok;
         bad_ff     <= req_bad;
         go_move_ff <= !req_bad && req_move;
      end
      if (cmd.cap_x) begin
         xf_ff <= f_rd_data;
         xb_ff <= b_rd_data;
      end
      if (cmd.cap_y) begin
         yf_ff <= yf_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.bad_request = bad_ff;
      priority if (!x_ok_ff) begin
         rsp_in.forward_neighbour  = '0;
         rsp_in.backward_neighbour = '0;
      end else if (go_move_ff) begin
         rsp_in.forward_neighbour  = NODE_W'(LNK_W'(yf_ff) + LNK_W'(1));
         rsp_in.backward_neighbour = NODE_W'(LNK_W'(y_ff) + LNK_W'(1));
      end else begin
         rsp_in.forward_neighbour  = NODE_W'(LNK_W'(xf_ff) + LNK_W'(1));
         rsp_in.backward_neighbour = NODE_W'(LNK_W'(xb_ff) + LNK_W'(1));
      end
   end

   // link table write port selection
   always_comb begin
      wr_en     = 1'b1;
      f_wr_addr = sweep_ff;
      f_wr_data = '0;
      b_wr_addr = sweep_ff;
      b_wr_data = '0;
      unique case (cmd.wr_sel)
         clm_pkg::WR_INIT: begin
            f_wr_data = (sweep_ff == last_idx) ? '0 : IDX_W'(sweep_ff + IDX_W'(1));
            b_wr_data = (sweep_ff == '0) ? last_idx : IDX_W'(sweep_ff - IDX_W'(1));
         end
         clm_pkg::WR_UNLINK: begin
            f_wr_addr = xb_ff;
            f_wr_data = xf_ff;
            b_wr_addr = xf_ff;
            b_wr_data = xb_ff;
         end
         clm_pkg::WR_SPLICE: begin
            f_wr_addr = x_ff;
            f_wr_data = yf_ff;
            b_wr_addr = x_ff;
            b_wr_data = y_ff;
         end
         clm_pkg::WR_CLOSE: begin
            f_wr_addr = y_ff;
            f_wr_data = x_ff;
            b_wr_addr = yf_ff;
            b_wr_data = x_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign f_rd_addr = cmd.rd_y ? y_ff : x_ff;

   clm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_NODES)
   ) u_fwd_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (f_wr_addr),
      .wr_data (f_wr_data),
      .rd_addr (f_rd_addr),
      .rd_data (f_rd_data)
   );

   clm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_NODES)
   ) u_bwd_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_addr (x_ff),
      .rd_data (b_rd_data)
   );

   assign sts.req_x_ok   = req_x_ok;
   assign sts.go_move    = go_move_ff;
   assign sts.sweep_last = (sweep_ff == last_idx);
   assign rsp_data       = rsp_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) && (count_ff <= CNT_W'(MAX_NODES)))
      else $error("node count outside its range");

   a_unlink_distinct: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == clm_pkg::WR_UNLINK) |-> (xf_ff != x_ff) && (xb_ff != x_ff))
      else $error("moved node linked to itself");

   a_close_distinct: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == clm_pkg::WR_CLOSE) |-> (yf_ff != x_ff) && (y_ff != x_ff))
      else $error("splice would close a self loop");
`endif

endmodule

`default_nettype wire

// ===== sv/circular_list_move_engine_top.sv =====
// A move passes RD_X, RD_Y, CAP_Y, SPLICE and CLOSE before DONE; a query or rejected
// request with a valid node x passes RD_X and RD_Y only; one whose x is out of range
// goes straight to DONE. No new beat is taken until DONE loads the result; the pace
// is set by the single forward link RAM read port and the three link rewrites of a splice.
// After reset, and after each node_count write, the ring is rebuilt one node per
// cycle (MAX_NODES nodes after reset) while req_ready stays low.
`default_nettype none

module circular_list_move_engine_top #(
   parameter int MAX_NODES = clm_pkg::MAX_NODES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire clm_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output clm_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [clm_pkg::NODE_W-1:0] csr_wdata
);

   clm_pkg::cmd_type cmd;
   clm_pkg::sts_type sts;

   clm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   clm_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the circular list move engine: ring predictor, driver and monitor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int NODE_W         = clm_pkg::NODE_W;
   localparam int NODE_MAX       = clm_pkg::MAX_NODES_DEF;
   localparam int FIELD_TOP      = (1 << NODE_W) - 1;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   clm_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   clm_pkg::rsp_type  rsp_data;
   logic              csr_we    = 1'b0;
   logic [NODE_W-1:0] csr_wdata = '0;

   // predicted ring, zero-based links as in the block's tables
   int unsigned ring_next [NODE_MAX];
   int unsigned ring_prev [NODE_MAX];
   int unsigned ring_size;

   clm_pkg::req_type beat_backlog[$];
   clm_pkg::rsp_type neighbours_due[$];

   int beats_queued   = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int idle_pct       = 0;
   bit rsp_long_hold  = 1'b0;
   int send_gap       = 0;
   int stall_left     = 0;
   int quiet_cycles   = 0;

   circular_list_move_engine_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void rebuild_ring(int unsigned count);
      int unsigned n;
      n = count;
      if (n < 2) n = 2;
      if (n > NODE_MAX) n = NODE_MAX;
      ring_size = n;
      for (int unsigned i = 0; i < n; i++) begin
         ring_next[i] = (i + 1 == n) ? 0 : i + 1;
         ring_prev[i] = (i == 0) ? n - 1 : i - 1;
      end
   endfunction

   function automatic clm_pkg::rsp_type move_node(clm_pkg::req_type beat);
      int unsigned      xn, yn, x, y, xf, xb, yf;
      bit               x_ok, bad;
      clm_pkg::rsp_type r;
      xn   = beat.node_moved;
      yn   = beat.node_target;
      x_ok = (xn >= 1) && (xn <= ring_size);
      bad  = !x_ok;
      if (beat.req_type == clm_pkg::REQ_MOVE && (yn < 1 || yn > ring_size || xn == yn))
         bad = 1'b1;
      if (!bad && beat.req_type == clm_pkg::REQ_MOVE) begin
         x  = xn - 1;
         y  = yn - 1;
         xf = ring_next[x];
         xb = ring_prev[x];
         ring_next[xb] = xf;
         ring_prev[xf] = xb;
         // y's successor is read after the unlink, so moving x behind its own predecessor is a no-op
         yf = ring_next[y];
         ring_prev[x]  = y;
         ring_next[x]  = yf;
         ring_prev[yf] = x;
         ring_next[y]  = x;
      end
      r = '0;
      if (x_ok) begin
         r.forward_neighbour  = NODE_W'(ring_next[xn - 1] + 1);
         r.backward_neighbour = NODE_W'(ring_prev[xn - 1] + 1);
      end
      r.bad_request = bad;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   task automatic queue_beat(logic kind, int xn, int yn);
      clm_pkg::req_type b;
      b.req_type    = kind;
      b.node_moved  = NODE_W'(xn);
      b.node_target = NODE_W'(yn);
      beat_backlog.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_random(int count);
      int   pick;
      logic kind;
      int   xn, yn;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         kind = ($urandom_range(0, 3) == 0) ? clm_pkg::REQ_QUERY : clm_pkg::REQ_MOVE;
         xn   = $urandom_range(1, ring_size);
         yn   = $urandom_range(1, ring_size);
         if (kind == clm_pkg::REQ_QUERY) yn = $urandom_range(0, FIELD_TOP);
         if (pick >= 94) begin
            xn = $urandom_range(0, FIELD_TOP);
            yn = $urandom_range(0, FIELD_TOP);
         end else if (pick >= 88) begin
            // just outside the ring on one side or the other
            if ($urandom_range(0, 1)) xn = $urandom_range(0, 1) ? 0 : ring_size + 1;
            else yn = $urandom_range(0, 1) ? 0 : ring_size + 1;
         end
         queue_beat(kind, xn, yn);
      end
   endtask

   task automatic wait_drained();
      while (results_seen < beats_queued) @(posedge clock);
   endtask

   task automatic set_node_count(int value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= NODE_W'(value);
      rebuild_ring(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) neighbours_due.push_back(move_node(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
               send_gap = $urandom_range(1, 7);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (beat_backlog.size() > 0) begin
               req_data  <= beat_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      clm_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (neighbours_due.size() == 0) begin
               report_mismatch("result beat with nothing expected", 1, 0);
            end else begin
               want = neighbours_due.pop_front();
               if (rsp_data.forward_neighbour !== want.forward_neighbour)
                  report_mismatch("forward_neighbour", rsp_data.forward_neighbour,
                                  want.forward_neighbour);
               if (rsp_data.backward_neighbour !== want.backward_neighbour)
                  report_mismatch("backward_neighbour", rsp_data.backward_neighbour,
                                  want.backward_neighbour);
               if (rsp_data.bad_request !== want.bad_request)
                  report_mismatch("bad_request", rsp_data.bad_request, want.bad_request);
            end
         end
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 7);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      rebuild_ring(NODE_MAX);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ring as left by reset, full size
      idle_pct = 20;
      queue_beat(clm_pkg::REQ_MOVE, NODE_MAX, 1);
      queue_beat(clm_pkg::REQ_QUERY, NODE_MAX, 0);
      queue_beat(clm_pkg::REQ_QUERY, 1, FIELD_TOP);
      queue_beat(clm_pkg::REQ_MOVE, 3, 2);
      queue_beat(clm_pkg::REQ_MOVE, NODE_MAX + 1, 1);
      queue_beat(clm_pkg::REQ_MOVE, 2, NODE_MAX + 1);
      queue_beat(clm_pkg::REQ_MOVE, 0, 5);
      queue_beat(clm_pkg::REQ_MOVE, 7, 0);
      queue_beat(clm_pkg::REQ_MOVE, 9, 9);
      queue_beat(clm_pkg::REQ_QUERY, FIELD_TOP, FIELD_TOP);
      queue_beat(clm_pkg::REQ_QUERY, 0, 0);
      queue_beat(clm_pkg::REQ_MOVE, 1, NODE_MAX);

      // zero is clamped up to the smallest ring
      set_node_count(0);
      queue_beat(clm_pkg::REQ_MOVE, 1, 2);
      queue_beat(clm_pkg::REQ_MOVE, 2, 1);
      queue_beat(clm_pkg::REQ_QUERY, 2, 0);
      queue_beat(clm_pkg::REQ_QUERY, 3, 0);
      queue_beat(clm_pkg::REQ_MOVE, 2, 3);
      queue_beat(clm_pkg::REQ_MOVE, 1, 1);

      set_node_count(1);
      queue_random(40);

      // above the maximum, clamped down
      set_node_count(FIELD_TOP);
      idle_pct = 30;
      queue_random(100);

      set_node_count(7);
      idle_pct = 10;
      queue_random(120);

      // sink holds off while the backlog keeps the source busy
      set_node_count(33);
      queue_random(150);
      rsp_long_hold = 1'b1;

      set_node_count(NODE_MAX);
      idle_pct = 25;
      queue_random(120);

      set_node_count(300);
      idle_pct = 0;
      queue_random(150);

      wait_drained();
      repeat (20) @(posedge clock);
      if (neighbours_due.size() != 0)
         report_mismatch("results still outstanding", 0, neighbours_due.size());
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
